>>> src/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_REG_W = 5;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // register select bit of paddr
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd4;

  localparam logic signed [VAL_W-1:0] READ_MISS = -32'sd1;
  localparam logic signed [KEY_W-1:0] NO_EVICT_KEY = 32'sd0;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

>>> src/lkvc_if.sv
// request and response channel interfaces
interface lkvc_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, func, lookup_key, write_value, input ready);
  modport sink   (input valid, func, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;
  logic signed [31:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

>>> src/lkvc_cell.sv
// one recency position of the lru list: holds an entry and compares its key
module lkvc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lkvc_pkg::entry_t entry_i,
  input  logic [31:0]    key_i,
  output lkvc_pkg::entry_t entry_o,
  output logic           match_o
);
  import lkvc_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q   <= entry_i.key;
      value_q <= entry_i.value;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign match_o = valid_q && (key_q == key_i);

endmodule

>>> src/lru_key_value_cache.sv
// top level of the lru key-value cache
// A row of MAX_ENTRIES cells ordered by recency, cell 0 the most recent. Every
// cell compares its key with the request in parallel; a hit or an insert moves
// the chosen entry to cell 0 while the cells above it hand their entries one
// place down. One item is taken per cycle unless an earlier result waits
// untaken: the whole lookup and list update happen at the accept edge, and
// the result sits in an output register so the next item is accepted in the
// cycle the previous result is taken. There is no clearing pass after reset.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkvc_pkg::*;

  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CAP_W  = (FILL_W > CAP_REG_W) ? FILL_W : CAP_REG_W;

  // configuration
  logic [CAP_REG_W-1:0] cap_q;
  logic [CAP_W-1:0]     cap_ext;
  logic [CAP_W-1:0]     cap_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES_IN_USE)) begin
      cap_q <= pwdata[CAP_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRIES_IN_USE) begin
      prdata = 32'(cap_q);
    end
  end

  always_comb begin
    cap_ext = CAP_W'(cap_q);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_ext > CAP_W'(MAX_ENTRIES)) begin
      cap_eff = CAP_W'(MAX_ENTRIES);
    end
  end

  // cell row
  entry_t                 cell_out [MAX_ENTRIES];
  entry_t                 new_entry;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] load_vec;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = new_entry;
    end else begin : g_body
      assign cell_in = cell_out[i-1];
    end
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load_vec[i]),
      .entry_i (cell_in),
      .key_i   (req.lookup_key),
      .entry_o (cell_out[i]),
      .match_o (match_vec[i])
    );
    assign valid_vec[i] = cell_out[i].valid;
  end

  // lookup
  logic             hit_any;
  logic [IDX_W-1:0] hit_pos;
  logic [VAL_W-1:0] hit_value;

  assign hit_any = |match_vec;

  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | cell_out[i].value;
      end
    end
  end

  // list update
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              accept;
  logic              is_set;
  logic              full;
  logic              do_evict;
  logic              do_insert;
  logic              do_update;
  logic [FILL_W-1:0] move_pos;
  logic [KEY_W-1:0]  evict_key;

  logic                   rsp_valid_q;
  logic                   hit_q;
  logic signed [VAL_W-1:0] read_value_q;
  logic                   evicted_q;
  logic signed [KEY_W-1:0] evicted_key_q;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_set    = (req.func == FUNC_SET);
  assign full      = (CAP_W'(fill_q) >= cap_eff);
  assign do_evict  = is_set && !hit_any && full;
  assign do_insert = is_set && !hit_any && !full;
  assign do_update = accept && (hit_any || is_set);

  always_comb begin
    if (hit_any) begin
      move_pos = FILL_W'(hit_pos);
    end else if (full) begin
      move_pos = fill_q - FILL_W'(1);
    end else begin
      move_pos = fill_q;
    end
  end

  // least recent valid entry, the one an eviction drops
  always_comb begin
    evict_key = NO_EVICT_KEY;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (FILL_W'(i) == move_pos) begin
        evict_key = cell_out[i].key;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      load_vec[i] = do_update && (FILL_W'(i) <= move_pos);
    end
  end

  assign new_entry = '{
    valid: 1'b1,
    key:   req.lookup_key,
    value: (hit_any && !is_set) ? hit_value : req.write_value
  };

  always_comb begin
    fill_d = fill_q;
    if (accept && do_insert) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q         <= hit_any;
      read_value_q  <= (hit_any && !is_set) ? hit_value : READ_MISS;
      evicted_q     <= do_evict;
      evicted_key_q <= do_evict ? evict_key : NO_EVICT_KEY;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.hit         = hit_q;
  assign rsp.read_value  = read_value_q;
  assign rsp.evicted     = evicted_q;
  assign rsp.evicted_key = evicted_key_q;

`ifndef SYNTHESIS
  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(fill_q))
    else $error("valid cells do not match fill count");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("key present in more than one cell");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_ENTRIES)
    else $error("fill count above row length");

  a_evict_excludes_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(hit_q && evicted_q))
    else $error("item reports both hit and eviction");
`endif

endmodule
